>>> sv/stu_pkg.sv
// Shared types, constants and helpers for the string to unsigned parser.
`timescale 1ns / 1ps
`default_nettype none

package stu_pkg;

  // Result word width and derived sizes
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BASE_BITS = 6;
  localparam int unsigned PROD_BITS = WORD_BITS + BASE_BITS + 1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [BASE_BITS-1:0] base_t;
  typedef logic [BASE_BITS-1:0] digit_t;

  localparam word_t WORD_ONES = {WORD_BITS{1'b1}};

  // Radix limits and fixed values
  localparam base_t BASE_MAX   = base_t'(36);
  localparam base_t BASE_RESET = base_t'(10);
  localparam base_t BASE_AUTO  = base_t'(0);
  localparam base_t BASE_OCT   = base_t'(8);
  localparam base_t BASE_DEC   = base_t'(10);
  localparam base_t BASE_HEX   = base_t'(16);
  localparam digit_t DIGIT_NONE = digit_t'(63);

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_BADBASE = 2'd2;

  // Radix substitution applied when the current radix is automatic
  typedef enum logic [1:0] {
    FIX_NONE,
    FIX_DEC,
    FIX_OCT,
    FIX_HEX
  } fix_t;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_base;   // latch the configured radix
    logic set_neg;   // minus sign seen
    fix_t fix;       // automatic radix resolution
    logic take;      // evaluate the character as a digit
    logic clear;     // last beat: capture result, clear string state
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_space;
    logic is_minus;
    logic is_plus;
    logic is_zero;
    logic is_x;
    logic cfg_bad;   // configured radix above the limit
    logic cfg_b016;  // configured radix is automatic or hex
    logic reg_b016;  // latched radix is automatic or hex
    logic dig_stop;  // digit rejected or accumulator would overflow
  } sts_t;

  // Digit value of a character, DIGIT_NONE for a non-digit
  function automatic digit_t digit_value(input logic [7:0] c);
    digit_t d;
    d = DIGIT_NONE;
    if (c >= CH_0 && c <= CH_9) begin
      d = digit_t'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = digit_t'(c - CH_UA + 8'd10);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = digit_t'(c - CH_LA + 8'd10);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> sv/stu_if.sv
// Valid/ready channel interfaces for character beats and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface stu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_string;

  modport source (output valid, character, end_of_string, input ready);
  modport sink   (input valid, character, end_of_string, output ready);
endinterface

interface stu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

`default_nettype wire

>>> sv/stu_dp.sv
// Datapath: radix register, accumulator with multiply-add, result register.
`timescale 1ns / 1ps
`default_nettype none

module stu_dp (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire [5:0]         cfg_wdata,
  input  wire [7:0]         in_character,
  input  stu_pkg::cmd_t     cmd,
  output stu_pkg::sts_t     sts,
  output logic [63:0]       res_value,
  output logic [1:0]        res_status
);

  stu_pkg::base_t num_base_r;
  stu_pkg::base_t base_r, base_nxt, base_use;
  stu_pkg::word_t acc_r, acc_nxt;
  logic           neg_r, neg_nxt;
  logic           ovf_r, ovf_nxt;

  stu_pkg::word_t res_acc_r;
  logic           res_neg_r;
  logic [1:0]     res_status_r;
  stu_pkg::word_t res_word;

  stu_pkg::digit_t                     dig;
  logic [stu_pkg::PROD_BITS-1:0]       sum;
  logic                                no_dig;
  logic                                ovf_hit;
  logic                                res_bad;
  logic                                res_err;

  // Radix in force for this beat, with automatic resolution
  always_comb begin
    base_use = cmd.ld_base ? num_base_r : base_r;
    base_nxt = base_use;
    if (base_use == stu_pkg::BASE_AUTO) begin
      case (cmd.fix)
        stu_pkg::FIX_DEC: base_nxt = stu_pkg::BASE_DEC;
        stu_pkg::FIX_OCT: base_nxt = stu_pkg::BASE_OCT;
        stu_pkg::FIX_HEX: base_nxt = stu_pkg::BASE_HEX;
        default:          base_nxt = base_use;
      endcase
    end
  end

  // Digit step: acc * base + digit, overflow when high bits are set
  assign dig     = stu_pkg::digit_value(in_character);
  assign sum     = stu_pkg::PROD_BITS'(acc_r) * stu_pkg::PROD_BITS'(base_nxt)
                 + stu_pkg::PROD_BITS'(dig);
  assign no_dig  = (base_nxt == stu_pkg::BASE_AUTO) || (dig >= base_nxt);
  assign ovf_hit = !no_dig && (|sum[stu_pkg::PROD_BITS-1:stu_pkg::WORD_BITS]);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.take && !no_dig && !ovf_hit) begin
      acc_nxt = sum[stu_pkg::WORD_BITS-1:0];
    end
    ovf_nxt = ovf_r || (cmd.take && ovf_hit);
    neg_nxt = neg_r || cmd.set_neg;
  end

  // Character classes and radix flags for the controller
  always_comb begin
    sts.is_space = (in_character == stu_pkg::CH_SPACE) || (in_character == stu_pkg::CH_FF)
                || (in_character == stu_pkg::CH_LF)    || (in_character == stu_pkg::CH_CR)
                || (in_character == stu_pkg::CH_TAB)   || (in_character == stu_pkg::CH_VT);
    sts.is_minus = (in_character == stu_pkg::CH_MINUS);
    sts.is_plus  = (in_character == stu_pkg::CH_PLUS);
    sts.is_zero  = (in_character == stu_pkg::CH_0);
    sts.is_x     = (in_character == stu_pkg::CH_LX) || (in_character == stu_pkg::CH_UX);
    sts.cfg_bad  = (num_base_r > stu_pkg::BASE_MAX);
    sts.cfg_b016 = (num_base_r == stu_pkg::BASE_AUTO) || (num_base_r == stu_pkg::BASE_HEX);
    sts.reg_b016 = (base_r == stu_pkg::BASE_AUTO) || (base_r == stu_pkg::BASE_HEX);
    sts.dig_stop = no_dig || ovf_hit;
  end

  // Final status from the state this beat leaves behind
  assign res_bad = (base_nxt > stu_pkg::BASE_MAX);
  assign res_err = res_bad || ovf_nxt;

  // String state, radix register and captured result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_base_r <= stu_pkg::BASE_RESET;
      base_r     <= stu_pkg::BASE_AUTO;
      acc_r      <= '0;
      neg_r      <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_base_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        base_r <= stu_pkg::BASE_AUTO;
        acc_r  <= '0;
        neg_r  <= 1'b0;
        ovf_r  <= 1'b0;
      end else begin
        base_r <= base_nxt;
        acc_r  <= acc_nxt;
        neg_r  <= neg_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      res_acc_r    <= res_err ? stu_pkg::WORD_ONES : acc_nxt;
      res_neg_r    <= neg_nxt && !res_err;
      res_status_r <= res_bad ? stu_pkg::ST_BADBASE :
                      (ovf_nxt ? stu_pkg::ST_RANGE : stu_pkg::ST_OK);
    end
  end

  // Two's complement applied on the way out
  assign res_word   = res_neg_r ? (stu_pkg::word_t'(0) - res_acc_r) : res_acc_r;
  assign res_value  = 64'(res_word);
  assign res_status = res_status_r;

endmodule

`default_nettype wire

>>> sv/stu_ctrl.sv
// Controller: parse phase state machine and result beat handshake.
`timescale 1ns / 1ps
`default_nettype none

module stu_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  input  wire            in_eos,
  input  wire            out_ready,
  input  stu_pkg::sts_t  sts,
  output stu_pkg::cmd_t  cmd,
  output logic           in_ready,
  output logic           out_valid
);

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   b016;

  // Result register frees up when empty or being drained
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign b016      = (phase_r == PH_LEAD) ? sts.cfg_b016 : sts.reg_b016;

  // Phase decode and commands
  always_comb begin
    cmd       = '0;
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r) inside
        PH_LEAD, PH_SIGNED: begin
          cmd.ld_base = (phase_r == PH_LEAD);
          if (phase_r == PH_LEAD && sts.cfg_bad) begin
            phase_nxt = PH_DONE;
          end else if (phase_r == PH_LEAD && sts.is_space) begin
            phase_nxt = PH_LEAD;
          end else if (phase_r == PH_LEAD && sts.is_minus) begin
            cmd.set_neg = 1'b1;
            phase_nxt   = PH_SIGNED;
          end else if (phase_r == PH_LEAD && sts.is_plus) begin
            phase_nxt = PH_SIGNED;
          end else if (b016 && sts.is_zero) begin
            phase_nxt = PH_ZERO;
          end else begin
            cmd.fix   = stu_pkg::FIX_DEC;
            cmd.take  = 1'b1;
            phase_nxt = sts.dig_stop ? PH_DONE : PH_DIGITS;
          end
        end
        PH_ZERO: begin
          if (sts.is_x) begin
            cmd.fix   = stu_pkg::FIX_HEX;
            phase_nxt = PH_DIGITS;
          end else begin
            cmd.fix   = stu_pkg::FIX_OCT;
            cmd.take  = 1'b1;
            phase_nxt = sts.dig_stop ? PH_DONE : PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          cmd.take  = 1'b1;
          phase_nxt = sts.dig_stop ? PH_DONE : PH_DIGITS;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
      // Last beat closes the string
      if (in_eos) begin
        cmd.clear = 1'b1;
        phase_nxt = PH_LEAD;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept && in_eos) begin
      out_valid_nxt = 1'b1;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/string_to_unsigned_parser.sv
// Top level of the streaming string to unsigned integer parser.
//
//  Channel   Dir  Payload                          Handshake
//  in_bus    in   character[7:0], end_of_string    valid/ready
//  out_bus   out  value[63:0], status[1:0]         valid/ready
//  cfg_*     in   cfg_wdata[5:0] (number_base)     cfg_we, no wait
//
// One character beat per cycle while in_bus.ready is high; the multiply-by-radix and add of the
// accumulator settle in the same cycle as the beat.
// A result appears in the cycle after the last character is accepted and is
// held in a result register until taken; a character beat is accepted only
// while that register is empty or being drained.
// in_bus.ready drops only while a result waits and out_bus.ready is low.
// Synchronous active low reset; radix resets to 10.
`timescale 1ns / 1ps
`default_nettype none

module string_to_unsigned_parser (
  input  wire          clk,
  input  wire          rst_n,
  stu_in_if.sink       in_bus,
  stu_out_if.source    out_bus,
  input  wire          cfg_we,
  input  wire [5:0]    cfg_wdata
);

  stu_pkg::cmd_t cmd;
  stu_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;

  stu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_eos    (in_bus.end_of_string),
    .out_ready (out_bus.ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  stu_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_character (in_bus.character),
    .cmd          (cmd),
    .sts          (sts),
    .res_value    (out_bus.value),
    .res_status   (out_bus.status)
  );

  assign in_bus.ready  = in_ready;
  assign out_bus.valid = out_valid;

  // Last character beat always produces a result beat next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready && in_bus.end_of_string |=> out_bus.valid)
    else $error("result beat missing after last character");

  // Input is held off only while a result is stuck
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> out_bus.valid && !out_bus.ready)
    else $error("input stalled without a pending result");

  // Error statuses carry a saturated word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && (out_bus.status == stu_pkg::ST_RANGE
                      || out_bus.status == stu_pkg::ST_BADBASE)
    |-> out_bus.value == 64'(stu_pkg::WORD_ONES))
    else $error("error result not saturated");

  // Status code three is never produced
  assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> out_bus.status != 2'd3)
    else $error("undefined status code");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the string to unsigned parser: directed strings, then random ones.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned IDLE_LIMIT    = 1000;  // cycles with no beat before giving up
  localparam int unsigned SETTLE_CYCLES = 8;     // quiet time before a radix write and at the end
  localparam int unsigned RANDOM_BEATS  = 580;
  localparam int unsigned PHASES        = 4;
  localparam int unsigned MAX_REPORTS   = 10;

  // Radix settings used besides the package ones
  localparam stu_pkg::base_t RADIX_UNARY = stu_pkg::base_t'(1);
  localparam stu_pkg::base_t RADIX_BIN   = stu_pkg::base_t'(2);
  localparam stu_pkg::base_t RADIX_BAD   = stu_pkg::base_t'(37);
  localparam stu_pkg::base_t RADIX_TOP   = stu_pkg::base_t'(63);

  typedef enum logic [2:0] {
    SCAN_BLANK,
    SCAN_SIGNED,
    SCAN_ZERO,
    SCAN_DIGITS,
    SCAN_HALT
  } scan_t;

  typedef logic [stu_pkg::PROD_BITS-1:0] prod_t;

  typedef struct packed {
    stu_pkg::word_t value;
    logic [1:0]     status;
  } result_t;

  typedef struct packed {
    bit      known;
    result_t res;
  } given_t;

  // One directed string; radix written first when wr is set
  typedef struct {
    bit             wr;
    stu_pkg::base_t radix;
    int             lead;    // raw byte sent ahead of the text, -1 for none
    string          text;
    bit             known;
    stu_pkg::word_t value;
    logic [1:0]     status;
  } probe_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [5:0] cfg_wdata;

  stu_in_if  in_bus ();
  stu_out_if out_bus ();

  string_to_unsigned_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Parser mirror state
  stu_pkg::base_t radix_reg = stu_pkg::BASE_RESET;
  scan_t          scan      = SCAN_BLANK;
  stu_pkg::word_t acc       = '0;
  bit             neg       = 1'b0;
  stu_pkg::base_t radix     = stu_pkg::BASE_AUTO;
  bit             ovf       = 1'b0;

  result_t    pending_results[$];
  given_t     directed_expect[$];
  logic [7:0] text[$];
  probe_t     probes[$];

  stu_pkg::base_t cur_radix   = stu_pkg::BASE_RESET;
  int             gap_pct     = 0;
  int             stall_pct   = 0;
  int             fault_count = 0;
  int             idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Conversion predictor
  // ---------------------------------------------------------------------------

  function automatic stu_pkg::digit_t char_digit(logic [7:0] c);
    if (c inside {[stu_pkg::CH_0:stu_pkg::CH_9]}) return stu_pkg::digit_t'(c[3:0]);
    if (c inside {[stu_pkg::CH_UA:stu_pkg::CH_UZ], [stu_pkg::CH_LA:stu_pkg::CH_LZ]})
      return stu_pkg::digit_t'({1'b0, c[4:0]} + 6'd9);
    return stu_pkg::DIGIT_NONE;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == stu_pkg::CH_SPACE || c == stu_pkg::CH_FF || c == stu_pkg::CH_LF
        || c == stu_pkg::CH_CR || c == stu_pkg::CH_TAB || c == stu_pkg::CH_VT;
  endfunction

  // Accumulate one digit; halt on a non-digit or when the word would overflow
  function automatic void take_digit(logic [7:0] c);
    stu_pkg::digit_t d;
    prod_t           prod;
    d = char_digit(c);
    scan = SCAN_DIGITS;
    if (radix == stu_pkg::BASE_AUTO || d >= radix) begin
      scan = SCAN_HALT;
    end else begin
      prod = prod_t'(acc) * prod_t'(radix) + prod_t'(d);
      if (prod > prod_t'(stu_pkg::WORD_ONES)) begin
        ovf  = 1'b1;
        scan = SCAN_HALT;
      end else begin
        acc = prod[stu_pkg::WORD_BITS-1:0];
      end
    end
  endfunction

  // First character past blanks and sign: a zero may open a prefix
  function automatic void after_sign(logic [7:0] c);
    if ((radix == stu_pkg::BASE_AUTO || radix == stu_pkg::BASE_HEX) && c == stu_pkg::CH_0) begin
      scan = SCAN_ZERO;
    end else begin
      if (radix == stu_pkg::BASE_AUTO) radix = stu_pkg::BASE_DEC;
      take_digit(c);
    end
  endfunction

  // Advance by one character; returns 1 with the result on the last one
  function automatic bit parse_char(logic [7:0] c, logic last, output result_t res);
    res = '0;
    case (scan)
      SCAN_BLANK: begin
        radix = radix_reg;
        if (radix > stu_pkg::BASE_MAX) begin
          scan = SCAN_HALT;
        end else if (!is_blank(c)) begin
          if (c == stu_pkg::CH_MINUS) begin
            neg  = 1'b1;
            scan = SCAN_SIGNED;
          end else if (c == stu_pkg::CH_PLUS) begin
            scan = SCAN_SIGNED;
          end else begin
            after_sign(c);
          end
        end
      end
      SCAN_SIGNED: after_sign(c);
      SCAN_ZERO: begin
        if (c == stu_pkg::CH_LX || c == stu_pkg::CH_UX) begin
          if (radix == stu_pkg::BASE_AUTO) radix = stu_pkg::BASE_HEX;
          scan = SCAN_DIGITS;
        end else begin
          if (radix == stu_pkg::BASE_AUTO) radix = stu_pkg::BASE_OCT;
          take_digit(c);
        end
      end
      SCAN_DIGITS: take_digit(c);
      default: scan = SCAN_HALT;
    endcase
    if (!last) return 1'b0;

    if (radix > stu_pkg::BASE_MAX) begin
      res.value  = stu_pkg::WORD_ONES;
      res.status = stu_pkg::ST_BADBASE;
    end else if (ovf) begin
      res.value  = stu_pkg::WORD_ONES;
      res.status = stu_pkg::ST_RANGE;
    end else begin
      res.value  = neg ? (~acc + stu_pkg::word_t'(1)) : acc;
      res.status = stu_pkg::ST_OK;
    end
    scan  = SCAN_BLANK;
    acc   = '0;
    neg   = 1'b0;
    radix = stu_pkg::BASE_AUTO;
    ovf   = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat monitor, result check and watchdog
  // ---------------------------------------------------------------------------

  task automatic report(string what, bit has_want, result_t want, result_t got);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      if (has_want)
        $display("tb_top: %s: expected value %h status %0d, got value %h status %0d",
                 what, want.value, want.status, got.value, got.status);
      else
        $display("tb_top: %s: got value %h status %0d", what, got.value, got.status);
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t got, want, res;
    given_t  given;
    bit      moved;
    if (rst_n) begin
      moved = 1'b0;
      // result beat against the oldest expectation
      if (out_bus.valid && out_bus.ready) begin
        moved      = 1'b1;
        got.value  = out_bus.value;
        got.status = out_bus.status;
        if (pending_results.size() == 0) begin
          report("result with nothing pending", 1'b0, '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value || got.status !== want.status)
            report("result mismatch", 1'b1, want, got);
        end
      end
      // character beat into the predictor
      if (in_bus.valid && in_bus.ready) begin
        moved = 1'b1;
        if (parse_char(in_bus.character, in_bus.end_of_string, res)) begin
          if (directed_expect.size() != 0) begin
            given = directed_expect.pop_front();
            if (given.known) res = given.res;
          end
          pending_results.push_back(res);
        end
      end
      if (cfg_we) radix_reg = cfg_wdata;

      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Result side back-pressure
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Send one character beat; returns at the falling edge after acceptance
  task automatic send_char(logic [7:0] c, logic last);
    bit taken;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.character     <= c;
    in_bus.end_of_string <= last;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_bus.ready;
      @(negedge clk);
    end
  endtask

  task automatic send_text();
    if (text.size() == 0) text.push_back(stu_pkg::CH_SPACE);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
    text.delete();
  endtask

  // Radix write once the parser is drained
  task automatic write_radix(stu_pkg::base_t b);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    cur_radix = b;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic stu_pkg::base_t pick_radix();
    case ($urandom_range(11)) inside
      0, 1:    return stu_pkg::BASE_AUTO;
      2:       return stu_pkg::BASE_HEX;
      3:       return stu_pkg::BASE_DEC;
      4:       return stu_pkg::BASE_OCT;
      5:       return RADIX_BIN;
      6:       return stu_pkg::BASE_MAX;
      7:       return RADIX_UNARY;
      8:       return stu_pkg::base_t'($urandom_range(63, 37));
      default: return stu_pkg::base_t'($urandom_range(36, 2));
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(5))
      0:       return stu_pkg::CH_SPACE;
      1:       return stu_pkg::CH_FF;
      2:       return stu_pkg::CH_LF;
      3:       return stu_pkg::CH_CR;
      4:       return stu_pkg::CH_TAB;
      default: return stu_pkg::CH_VT;
    endcase
  endfunction

  function automatic logic [7:0] digit_char(int unsigned d);
    if (d < 10) return stu_pkg::CH_0 + 8'(d);
    return ($urandom_range(1) ? stu_pkg::CH_UA : stu_pkg::CH_LA) + 8'(d - 10);
  endfunction

  // Random string: mostly well-formed numbers, some raw noise
  task automatic build_string();
    int unsigned    eff;
    stu_pkg::word_t v;
    bit             big;
    logic [7:0]     digs[$];
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(6, 1)) text.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(2)) text.push_back(blank_char());
    case ($urandom_range(3))
      0:       text.push_back(stu_pkg::CH_MINUS);
      1:       text.push_back(stu_pkg::CH_PLUS);
      default: eff = 0;
    endcase

    eff = (cur_radix < RADIX_BIN || cur_radix > stu_pkg::BASE_MAX) ? 10 : cur_radix;
    if ((cur_radix == stu_pkg::BASE_AUTO || cur_radix == stu_pkg::BASE_HEX)
        && $urandom_range(2) == 0) begin
      text.push_back(stu_pkg::CH_0);
      text.push_back($urandom_range(1) ? stu_pkg::CH_LX : stu_pkg::CH_UX);
      eff = 16;
    end else if (cur_radix == stu_pkg::BASE_AUTO && $urandom_range(3) == 0) begin
      text.push_back(stu_pkg::CH_0);
      eff = 8;
    end

    // digit body; near the top of the word now and then
    if ($urandom_range(9) != 0) begin
      big = 1'b1;
      case ($urandom_range(9)) inside
        0, 1:    v = stu_pkg::WORD_ONES - stu_pkg::word_t'($urandom_range(2));
        2, 3:    v = {$urandom, $urandom};
        default: begin
          v   = stu_pkg::word_t'($urandom_range(999));
          big = 1'b0;
        end
      endcase
      do begin
        digs.push_front(digit_char(int'(v % stu_pkg::word_t'(eff))));
        v = v / stu_pkg::word_t'(eff);
      end while (v != 0);
      foreach (digs[i]) text.push_back(digs[i]);
      if (big && $urandom_range(3) == 0) text.push_back(digit_char($urandom_range(eff - 1)));
    end
    if ($urandom_range(9) < 3) text.push_back(8'($urandom_range(255)));
  endtask

  initial begin
    int     sent;
    int     strings;
    given_t given;
    int     gap_set[PHASES]   = '{0, 50, 0, 8};
    int     stall_set[PHASES] = '{0, 0, 50, 8};

    in_bus.valid         = 1'b0;
    in_bus.character     = '0;
    in_bus.end_of_string = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    rst_n                = 1'b0;

    probes = '{
      '{0, stu_pkg::BASE_RESET, -1, "7",                      1, 64'd7,   stu_pkg::ST_OK},
      '{0, stu_pkg::BASE_RESET, -1, "\011\012\013\014\015 4", 1, 64'd4,   stu_pkg::ST_OK},
      '{0, stu_pkg::BASE_RESET, -1, "-1",  1, stu_pkg::WORD_ONES, stu_pkg::ST_OK},
      '{0, stu_pkg::BASE_RESET, -1, "+9",                     1, 64'd9,   stu_pkg::ST_OK},
      '{0, stu_pkg::BASE_RESET, -1, " ",                      1, 64'd0,   stu_pkg::ST_OK},
      '{0, stu_pkg::BASE_RESET, -1, "-",                      1, 64'd0,   stu_pkg::ST_OK},
      '{0, stu_pkg::BASE_RESET,  0, "5",                      1, 64'd0,   stu_pkg::ST_OK},
      '{1, stu_pkg::BASE_HEX,   -1, "0x",                     1, 64'd0,   stu_pkg::ST_OK},
      '{0, stu_pkg::BASE_HEX,   -1, "0XfF",                   1, 64'd255, stu_pkg::ST_OK},
      '{1, stu_pkg::BASE_AUTO,  -1, "010",                    1, 64'd8,   stu_pkg::ST_OK},
      '{0, stu_pkg::BASE_AUTO,  -1, "-0x1A",                  0, 64'd0,   stu_pkg::ST_OK},
      '{1, RADIX_UNARY,         -1, "10",                     1, 64'd0,   stu_pkg::ST_OK},
      '{1, RADIX_BAD,           -1, "5", 1, stu_pkg::WORD_ONES, stu_pkg::ST_BADBASE},
      '{1, RADIX_TOP,           -1, "+", 1, stu_pkg::WORD_ONES, stu_pkg::ST_BADBASE},
      '{1, RADIX_BIN,           -1, "101",                    1, 64'd5,   stu_pkg::ST_OK},
      '{1, stu_pkg::BASE_MAX,   -1, "Zz",                     0, 64'd0,   stu_pkg::ST_OK},
      '{0, stu_pkg::BASE_MAX,   -1, "zzzzzzzzzzzzz",
        1, stu_pkg::WORD_ONES, stu_pkg::ST_RANGE},
      '{1, stu_pkg::BASE_OCT,   -1, "77!7",                   0, 64'd0,   stu_pkg::ST_OK}
    };

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed strings, no idling
    foreach (probes[i]) begin
      if (probes[i].wr) write_radix(probes[i].radix);
      given.known      = probes[i].known;
      given.res.value  = probes[i].value;
      given.res.status = probes[i].status;
      directed_expect.push_back(given);
      if (probes[i].lead >= 0) text.push_back(8'(probes[i].lead));
      for (int k = 0; k < probes[i].text.len(); k++) text.push_back(probes[i].text[k]);
      send_text();
    end

    // random strings over the idling phases, radix changed now and then
    for (int p = 0; p < PHASES; p++) begin
      write_radix(pick_radix());
      gap_pct   = gap_set[p];
      stall_pct = stall_set[p];
      sent      = 0;
      strings   = 0;
      while (sent < RANDOM_BEATS / PHASES) begin
        if (strings % 12 == 11) write_radix(pick_radix());
        build_string();
        sent += text.size();
        send_text();
        strings++;
      end
    end

    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fault_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> string_to_unsigned_parser.f
sv/stu_pkg.sv
sv/stu_if.sv
sv/stu_dp.sv
sv/stu_ctrl.sv
sv/string_to_unsigned_parser.sv
tb/tb_top.sv
